>>> design/video_ram_port_with_dirty_marks_macros.svh
// Assertion macros for the video RAM port with dirty marks.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef VIDEO_RAM_PORT_WITH_DIRTY_MARKS_MACROS_SVH
`define VIDEO_RAM_PORT_WITH_DIRTY_MARKS_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define VRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define VRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define VRP_ASSERT_NOW(label, ante, cons)
`define VRP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/vrp_pkg.sv
// Shared types and constants of the video RAM port with dirty marks.
// No dependencies.
`default_nettype none

package vrp_pkg;

  localparam int TILE_MAP_DEPTH = 2048;
  localparam int COLOR_ENTRIES  = 32;
  localparam int MAP_AW         = $clog2(TILE_MAP_DEPTH);
  localparam int COLOR_AW       = $clog2(COLOR_ENTRIES);

  localparam int ADDR_W    = 14;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 3;
  localparam int COLOR_W   = 6;
  localparam int COLS_W    = 64;
  localparam int ROW_W     = 32;
  localparam int COUNT_W   = 32;
  localparam int HUD_ROWS  = 3;

  localparam logic [9:0]        ATTR_START   = 10'd960;
  localparam logic [BYTE_W-1:0] STATUS_SET   = 8'hC0;
  // upper six address bits of the palette page (0x3F00 and up)
  localparam logic [5:0]        PALETTE_PAGE = 6'h3F;

  typedef enum logic [CMD_W-1:0] {
    CMD_STATUS     = 3'd0,
    CMD_DATA_READ  = 3'd1,
    CMD_SCROLL     = 3'd2,
    CMD_ADDRESS    = 3'd3,
    CMD_DATA_WRITE = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  // Palette index; the background copies at 0x10/0x14/0x18/0x1C fold down.
  function automatic logic [COLOR_AW-1:0] color_slot(input logic [ADDR_W-1:0] a);
    logic [COLOR_AW-1:0] i;
    i = a[COLOR_AW-1:0];
    if (i[COLOR_AW-1] && (i[1:0] == 2'd0)) begin
      i[COLOR_AW-1] = 1'b0;
    end
    return i;
  endfunction

endpackage

`default_nettype wire

>>> design/vrp_in_if.sv
// Bus access channel of the video RAM port.
// Depends on vrp_pkg.
`default_nettype none

interface vrp_in_if;
  import vrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, output cmd, output write_byte, input ready);
  modport sink   (input valid, input cmd, input write_byte, output ready);
endinterface

`default_nettype wire

>>> design/vrp_out_if.sv
// Result channel of the video RAM port.
// Depends on vrp_pkg.
`default_nettype none

interface vrp_out_if;
  import vrp_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  read_byte;
  logic [BYTE_W-1:0]  scroll_horizontal;
  logic [BYTE_W-1:0]  scroll_vertical;
  logic [ADDR_W-1:0]  current_address;
  logic [COLS_W-1:0]  background_dirty;
  logic [COLS_W-1:0]  hud_background_dirty;
  logic [ROW_W-1:0]   hud_row_one_dirty;
  logic [ROW_W-1:0]   hud_row_two_dirty;
  logic [ROW_W-1:0]   hud_row_three_dirty;
  logic [COUNT_W-1:0] hud_change_count;
  logic [COUNT_W-1:0] palette_change_count;

  modport source (
    output valid, output read_byte, output scroll_horizontal, output scroll_vertical,
    output current_address, output background_dirty, output hud_background_dirty,
    output hud_row_one_dirty, output hud_row_two_dirty, output hud_row_three_dirty,
    output hud_change_count, output palette_change_count, input ready
  );
  modport sink (
    input valid, input read_byte, input scroll_horizontal, input scroll_vertical,
    input current_address, input background_dirty, input hud_background_dirty,
    input hud_row_one_dirty, input hud_row_two_dirty, input hud_row_three_dirty,
    input hud_change_count, input palette_change_count, output ready
  );
endinterface

`default_nettype wire

>>> design/vrp_cfg_if.sv
// Configuration write channel of the video RAM port.
// No dependencies.
`default_nettype none

interface vrp_cfg_if;
  logic valid;
  logic ready;
  logic increment_by_32;

  modport source (output valid, output increment_by_32, input ready);
  modport sink   (input valid, input increment_by_32, output ready);
endinterface

`default_nettype wire

>>> design/vrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/video_ram_port_with_dirty_marks.sv
// Top level of the video RAM port with dirty marks.
// Depends on vrp_pkg, the three channel interfaces, vrp_ram and the macro header.
//
//   channel   port     dir  carries
//   -------   -------  ---  -----------------------------------------------
//   access    in_bus   in   cmd, write_byte
//   result    out_bus  out  read byte, scroll, address, marks, counters
//   config    cfg_bus  in   increment_by_32 (always taken)
//
// Each word goes through ST_IDLE and ST_LOOK: the accept edge reads the tile map
// and palette RAMs; ST_LOOK compares, writes back and loads the result register.
// That read-modify-write on the single tile map port keeps in_bus.ready low until
// the word is finished. After reset a clearing pass zeroes both RAMs, and
// in_bus.ready stays low meanwhile. A stalled result holds the word in ST_LOOK.
`default_nettype none

`include "video_ram_port_with_dirty_marks_macros.svh"

module video_ram_port_with_dirty_marks (
  input wire logic clk,
  input wire logic rst_n,
  vrp_in_if.sink   in_bus,
  vrp_out_if.source out_bus,
  vrp_cfg_if.sink  cfg_bus
);
  import vrp_pkg::*;

  state_t state_r, state_nxt;
  logic [MAP_AW-1:0] clr_idx_r;

  logic              inc32_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [BYTE_W-1:0] wbyte_r;

  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               second_r, second_nxt;
  logic [BYTE_W-1:0]  rbuf_r, rbuf_nxt;
  logic               toggle_r, toggle_nxt;
  logic [BYTE_W-1:0]  scroll_x_r, scroll_x_nxt;
  logic [BYTE_W-1:0]  scroll_y_r, scroll_y_nxt;
  logic [COLS_W-1:0]  full_cols_r, full_cols_nxt;
  logic [COLS_W-1:0]  hud_cols_r, hud_cols_nxt;
  logic [ROW_W-1:0]   hud_rows_r [HUD_ROWS];
  logic [ROW_W-1:0]   hud_rows_nxt [HUD_ROWS];
  logic [COUNT_W-1:0] hud_count_r, hud_count_nxt;
  logic [COUNT_W-1:0] pal_count_r, pal_count_nxt;
  logic [BYTE_W-1:0]  rd_byte;

  logic out_valid_r;
  logic slot_free, in_fire, finish;

  // RAM ports
  logic               map_we, pal_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [BYTE_W-1:0]  map_wdata, map_rdata;
  logic [COLOR_AW-1:0] pal_waddr;
  logic [COLOR_W-1:0]  pal_wdata, pal_rdata;

  // address decode
  logic               is_pattern, is_palette;
  logic [9:0]         map_off;
  logic               map_hi;
  logic [4:0]         row;
  logic [5:0]         col, attr, first;
  logic [COLOR_W-1:0] new_color;
  logic               map_changed, pal_changed;

  assign in_fire   = in_bus.valid && in_bus.ready;
  assign slot_free = !out_valid_r || out_bus.ready;
  assign finish    = (state_r == ST_LOOK) && slot_free;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = out_valid_r;

  assign is_pattern = !addr_r[ADDR_W-1];
  assign is_palette = (addr_r[ADDR_W-1:ADDR_W-6] == PALETTE_PAGE);
  assign map_off    = addr_r[9:0];
  assign map_hi     = addr_r[10];
  assign row        = map_off[9:5];
  assign col        = {map_hi, map_off[4:0]};
  assign attr       = map_off[5:0];
  assign first      = {map_hi, attr[2:0], 2'b00};
  assign new_color  = wbyte_r[COLOR_W-1:0];

  assign map_changed = finish && (cmd_r == CMD_DATA_WRITE) && !is_pattern && !is_palette
                       && (map_rdata != wbyte_r);
  assign pal_changed = finish && (cmd_r == CMD_DATA_WRITE) && is_palette
                       && (pal_rdata != new_color);

  // Clearing pass owns the write ports until it is done.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_idx_r;
      map_wdata = '0;
      pal_we    = (clr_idx_r[MAP_AW-1:COLOR_AW] == '0);
      pal_waddr = clr_idx_r[COLOR_AW-1:0];
      pal_wdata = '0;
    end else begin
      map_we    = map_changed;
      map_waddr = addr_r[MAP_AW-1:0];
      map_wdata = wbyte_r;
      pal_we    = pal_changed;
      pal_waddr = color_slot(addr_r);
      pal_wdata = new_color;
    end
  end

  vrp_ram #(.WIDTH(BYTE_W), .DEPTH(TILE_MAP_DEPTH)) u_tile_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (addr_r[MAP_AW-1:0]),
    .rdata (map_rdata)
  );

  vrp_ram #(.WIDTH(COLOR_W), .DEPTH(COLOR_ENTRIES)) u_color_table (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (color_slot(addr_r)),
    .rdata (pal_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // command execution
  always_comb begin
    addr_nxt      = addr_r;
    second_nxt    = second_r;
    rbuf_nxt      = rbuf_r;
    toggle_nxt    = toggle_r;
    scroll_x_nxt  = scroll_x_r;
    scroll_y_nxt  = scroll_y_r;
    full_cols_nxt = full_cols_r;
    hud_cols_nxt  = hud_cols_r;
    for (int i = 0; i < HUD_ROWS; i++) begin
      hud_rows_nxt[i] = hud_rows_r[i];
    end
    hud_count_nxt = hud_count_r;
    pal_count_nxt = pal_count_r;
    rd_byte       = '0;

    case (cmd_r)
      CMD_STATUS: begin
        toggle_nxt = !toggle_r;
        second_nxt = 1'b0;
        rd_byte    = toggle_r ? STATUS_SET : '0;
      end
      CMD_DATA_READ: begin
        rd_byte = rbuf_r;
        if (is_pattern) begin
          rbuf_nxt = '0;
        end else if (is_palette) begin
          rbuf_nxt = {{(BYTE_W-COLOR_W){1'b0}}, pal_rdata};
        end else begin
          rbuf_nxt = map_rdata;
        end
        addr_nxt = addr_r + (inc32_r ? ADDR_W'(32) : ADDR_W'(1));
      end
      CMD_SCROLL: begin
        if (!second_r) begin
          scroll_x_nxt = wbyte_r;
        end else begin
          scroll_y_nxt = wbyte_r;
        end
        second_nxt = !second_r;
      end
      CMD_ADDRESS: begin
        if (second_r) begin
          addr_nxt = {addr_r[ADDR_W-1:8], wbyte_r};
        end else begin
          addr_nxt = {wbyte_r[ADDR_W-9:0], addr_r[7:0]};
        end
        second_nxt = !second_r;
      end
      CMD_DATA_WRITE: begin
        addr_nxt = addr_r + (inc32_r ? ADDR_W'(32) : ADDR_W'(1));
        if (pal_changed) begin
          pal_count_nxt = pal_count_r + 1'b1;
        end
        if (map_changed) begin
          if (map_off < ATTR_START) begin
            if (row inside {[5'd1:5'd28]}) begin
              full_cols_nxt = full_cols_r | (COLS_W'(1) << col);
            end
            if (row inside {[5'd4:5'd29]}) begin
              hud_cols_nxt = hud_cols_r | (COLS_W'(1) << col);
            end
            if (!map_hi && (row inside {[5'd1:5'd3]})) begin
              hud_rows_nxt[row[1:0] - 2'd1] = hud_rows_r[row[1:0] - 2'd1]
                                              | (ROW_W'(1) << col[4:0]);
              hud_count_nxt = hud_count_r + 1'b1;
            end
          end else begin
            // attribute byte covers four columns
            full_cols_nxt = full_cols_r | (COLS_W'(4'hF) << first);
            if (attr[5:3] != 3'd0) begin
              hud_cols_nxt = hud_cols_r | (COLS_W'(4'hF) << first);
            end
            if (!map_hi && (attr[5:3] == 3'd0)) begin
              for (int i = 0; i < HUD_ROWS; i++) begin
                hud_rows_nxt[i] = hud_rows_r[i] | (ROW_W'(4'hF) << first[4:0]);
              end
              hud_count_nxt = hud_count_r + 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        full_cols_nxt = '0;
        hud_cols_nxt  = '0;
        for (int i = 0; i < HUD_ROWS; i++) begin
          hud_rows_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc32_r     <= 1'b0;
      addr_r      <= '0;
      second_r    <= 1'b0;
      rbuf_r      <= '0;
      toggle_r    <= 1'b0;
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
      full_cols_r <= '0;
      hud_cols_r  <= '0;
      for (int i = 0; i < HUD_ROWS; i++) begin
        hud_rows_r[i] <= '0;
      end
      hud_count_r <= '0;
      pal_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        inc32_r <= cfg_bus.increment_by_32;
      end
      if (finish) begin
        addr_r      <= addr_nxt;
        second_r    <= second_nxt;
        rbuf_r      <= rbuf_nxt;
        toggle_r    <= toggle_nxt;
        scroll_x_r  <= scroll_x_nxt;
        scroll_y_r  <= scroll_y_nxt;
        full_cols_r <= full_cols_nxt;
        hud_cols_r  <= hud_cols_nxt;
        for (int i = 0; i < HUD_ROWS; i++) begin
          hud_rows_r[i] <= hud_rows_nxt[i];
        end
        hud_count_r <= hud_count_nxt;
        pal_count_r <= pal_count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // latch the accepted word and the result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_bus.cmd;
      wbyte_r <= in_bus.write_byte;
    end
    if (finish) begin
      out_bus.read_byte            <= rd_byte;
      out_bus.scroll_horizontal    <= scroll_x_nxt;
      out_bus.scroll_vertical      <= scroll_y_nxt;
      out_bus.current_address      <= addr_nxt;
      out_bus.background_dirty     <= full_cols_nxt;
      out_bus.hud_background_dirty <= hud_cols_nxt;
      out_bus.hud_row_one_dirty    <= hud_rows_nxt[0];
      out_bus.hud_row_two_dirty    <= hud_rows_nxt[1];
      out_bus.hud_row_three_dirty  <= hud_rows_nxt[2];
      out_bus.hud_change_count     <= hud_count_nxt;
      out_bus.palette_change_count <= pal_count_nxt;
    end
  end

  `VRP_ASSERT_NEXT(a_accept_enters_look, in_fire, state_r == ST_LOOK)
  `VRP_ASSERT_NEXT(a_finish_loads_result, finish, out_valid_r)
  `VRP_ASSERT_NOW(a_no_result_while_clearing, state_r == ST_CLEAR, !out_valid_r)
  `VRP_ASSERT_NEXT(a_counters_move_only_on_finish, !finish,
                   (hud_count_r == $past(hud_count_r)) && (pal_count_r == $past(pal_count_r)))

endmodule

`default_nettype wire
